FILE: hdl/cpid_pkg.sv
// Shared types and constants of the column post image decoder.
package cpid_pkg;

  localparam int MAX_COLUMNS_DEF = 4096;

  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_NEW  = 2'd2;

  localparam logic [1:0] CFG_CLIP_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_MASK_ZERO   = 2'd1;
  localparam logic [1:0] CFG_XLAT_EN     = 2'd2;

  localparam logic [7:0]  END_OF_COLUMN = 8'hff;
  localparam logic [15:0] ROW_MAX       = 16'hffff;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] table_index;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] column;
    logic [15:0] row;
    logic        write_color;
    logic [7:0]  color_index;
    logic        opaque;
    logic [15:0] extent_height;
  } out_word_t;

  typedef struct packed {
    logic [7:0] q;
    logic       hit;
  } xlat_rd_t;

endpackage

FILE: hdl/cpid_xlat.sv
// Translation table: 256x8 memory with per-entry valid bits, identity until loaded.
module cpid_xlat
  import cpid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic     re,
  input  logic [7:0] raddr,
  output xlat_rd_t rd
);

  logic [7:0]   mem [256];
  logic [255:0] valid_r;
  logic [7:0]   q_r;
  logic         hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        hit_r <= valid_r[raddr];
      end
    end
  end

  assign rd.q   = q_r;
  assign rd.hit = hit_r;

endmodule

FILE: hdl/cpid_parse.sv
// Post list parser: config registers, column state and result formation.
module cpid_parse
  import cpid_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  item,
  input  xlat_rd_t  rd,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic      res_valid,
  output out_word_t res_word
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [2:0] {
    PH_TOP, PH_LEN, PH_JUNK1, PH_PIX, PH_JUNK2
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic          tall_vld_r, tall_vld_nxt;
  logic [15:0]   tall_r, tall_nxt;
  logic [7:0]    left_r, left_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   ext_top_r, ext_top_nxt;
  logic [15:0]   ext_bot_r, ext_bot_nxt;
  logic          ext_vld_r, ext_vld_nxt;
  logic [15:0]   clip_r;
  logic          mask_zero_r;
  logic          xlat_en_r;

  logic [16:0] sum;
  logic [15:0] sum_sat;
  logic [7:0]  b;
  logic [7:0]  idx;

  assign b       = item.data_byte;
  assign sum     = {1'b0, tall_r} + {9'b0, b};
  assign sum_sat = sum[16] ? ROW_MAX : sum[15:0];
  assign idx     = (xlat_en_r && rd.hit) ? rd.q : b;

  always_comb begin
    phase_nxt    = phase_r;
    tall_vld_nxt = tall_vld_r;
    tall_nxt     = tall_r;
    left_nxt     = left_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    ext_top_nxt  = ext_top_r;
    ext_bot_nxt  = ext_bot_r;
    ext_vld_nxt  = ext_vld_r;
    res_valid    = 1'b0;
    res_word     = '0;
    if (step) begin
      if (item.mode == MODE_NEW) begin
        phase_nxt    = PH_TOP;
        tall_vld_nxt = 1'b0;
        left_nxt     = '0;
        row_nxt      = '0;
        col_nxt      = '0;
        ext_top_nxt  = '0;
        ext_bot_nxt  = '0;
        ext_vld_nxt  = 1'b0;
      end else if (item.mode == MODE_DATA) begin
        unique case (phase_r)
          PH_TOP: begin
            if (b == END_OF_COLUMN) begin
              res_valid       = 1'b1;
              res_word.kind   = KIND_COLUMN;
              res_word.column = 12'(col_r);
              res_word.extent_height = ext_vld_r ? (ext_bot_r - ext_top_r) : 16'd0;
              col_nxt = (col_r == CW'(MAX_COLUMNS - 1)) ? '0 : col_r + 1'b1;
              tall_vld_nxt = 1'b0;
            end else begin
              if (tall_vld_r && ({8'b0, b} <= tall_r)) begin
                tall_nxt = sum_sat;
              end else begin
                tall_nxt = {8'b0, b};
              end
              tall_vld_nxt = 1'b1;
              phase_nxt    = PH_LEN;
            end
          end
          PH_LEN: begin
            left_nxt = b;
            row_nxt  = tall_r;
            if (b != 8'd0) begin
              ext_vld_nxt = 1'b1;
              if (!ext_vld_r) begin
                ext_top_nxt = tall_r;
                ext_bot_nxt = sum_sat;
              end else begin
                if (tall_r < ext_top_r) ext_top_nxt = tall_r;
                if (sum_sat > ext_bot_r) ext_bot_nxt = sum_sat;
              end
            end
            phase_nxt = PH_JUNK1;
          end
          PH_JUNK1: begin
            phase_nxt = (left_r != 8'd0) ? PH_PIX : PH_JUNK2;
          end
          PH_PIX: begin
            if (row_r != ROW_MAX) row_nxt = row_r + 16'd1;
            left_nxt = left_r - 8'd1;
            if (left_nxt == 8'd0) phase_nxt = PH_JUNK2;
            if (row_r < clip_r) begin
              res_valid            = 1'b1;
              res_word.kind        = KIND_PIXEL;
              res_word.column      = 12'(col_r);
              res_word.row         = row_r;
              res_word.write_color = !mask_zero_r || (idx != 8'd0);
              res_word.color_index = idx;
              res_word.opaque      = !mask_zero_r || (idx != 8'd0);
            end
          end
          default: begin
            phase_nxt = PH_TOP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOP;
      tall_vld_r  <= 1'b0;
      tall_r      <= '0;
      left_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ext_top_r   <= '0;
      ext_bot_r   <= '0;
      ext_vld_r   <= 1'b0;
      clip_r      <= ROW_MAX;
      mask_zero_r <= 1'b0;
      xlat_en_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      tall_vld_r <= tall_vld_nxt;
      tall_r     <= tall_nxt;
      left_r     <= left_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      ext_top_r  <= ext_top_nxt;
      ext_bot_r  <= ext_bot_nxt;
      ext_vld_r  <= ext_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLIP_HEIGHT: clip_r      <= cfg_data;
          CFG_MASK_ZERO:   mask_zero_r <= cfg_data[0];
          CFG_XLAT_EN:     xlat_en_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/column_post_image_decoder.sv
// Column post image decoder top level: input stage, table, parser, output register.
// An accepted word is held in the input stage register; its result goes to the output register.
// One input word per cycle while the output is not stalled; the table read is registered in the input stage.
// Reset (synchronous, rst_n low): parser, column count and extent cleared, registers to
// defaults; translation table reads as identity until entries are loaded. No clearing pass.
module column_post_image_decoder
  import cpid_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic      s1_vld_r;
  in_word_t  s1_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  logic      adv;
  logic      step;
  logic      in_acc;
  logic      res_valid;
  out_word_t res_word;
  xlat_rd_t  rd;

  assign adv      = !out_vld_r || !out_stall;
  assign step     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  cpid_xlat u_xlat (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (in_acc && (in_word.mode == MODE_LOAD)),
    .waddr (in_word.table_index),
    .wdata (in_word.data_byte),
    .re    (in_acc),
    .raddr (in_word.data_byte),
    .rd    (rd)
  );

  cpid_parse #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_word_r),
    .rd        (rd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (step) begin
        s1_vld_r <= 1'b0;
      end
      if (step && res_valid) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_word;
    end
    if (step && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule
